FILE: rtl/csks_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csks_pkg
// shared constants, codes and memory port types of the chunked key search
// ----------------------------------------------------------------------------
package csks_pkg;

	localparam int KEY_W       = 64;
	localparam int CHUNK_SEL_W = 4;
	localparam int CHUNK_SIZE  = 64;
	localparam int CHUNK_LOG   = $clog2(CHUNK_SIZE);
	localparam int NUM_CHUNKS  = 1 << CHUNK_SEL_W;
	localparam int ADDR_W      = CHUNK_SEL_W + CHUNK_LOG;
	localparam int TABLE_DEPTH = 1 << ADDR_W;
	localparam int POS_W       = ADDR_W + 1;
	localparam int CNT_W       = $clog2(CHUNK_SIZE + 1);
	localparam int ACT_W       = 2;

	typedef enum logic [ACT_W-1:0] {
		ACT_WRITE_KEY   = 2'd0,
		ACT_WRITE_COUNT = 2'd1,
		ACT_SEARCH      = 2'd2
	} action_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [KEY_W-1:0]  data;
	} ram_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} ram_rd_t;

endpackage

FILE: rtl/csks_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csks_req_if
// request channel: key writes, count writes and searches
// ----------------------------------------------------------------------------
interface csks_req_if;
	logic                        valid;
	logic                        ready;
	logic [csks_pkg::ACT_W-1:0]  action;
	logic [csks_pkg::ADDR_W-1:0] address;
	logic [csks_pkg::KEY_W-1:0]  key;
	logic [csks_pkg::CNT_W-1:0]  count;

	modport source(output valid, action, address, key, count, input ready);
	modport sink(input valid, action, address, key, count, output ready);
endinterface

FILE: rtl/csks_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csks_rsp_if
// response channel: search results
// ----------------------------------------------------------------------------
interface csks_rsp_if;
	logic                             valid;
	logic                             ready;
	logic                             found;
	logic [csks_pkg::ADDR_W-1:0]      match_position;
	logic [csks_pkg::POS_W-1:0]       insert_position;
	logic [csks_pkg::CHUNK_SEL_W-1:0] chunk_number;

	modport source(output valid, found, match_position, insert_position, chunk_number,
		input ready);
	modport sink(input valid, found, match_position, insert_position, chunk_number,
		output ready);
endinterface

FILE: rtl/chunked_sorted_key_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunked_sorted_key_search
// bucketed lower-bound search over a chunked table of sorted 64-bit keys
// ----------------------------------------------------------------------------
// usage
//  req channel (valid/ready): action selects a key write, a count write or a
//   search; key writes go to table position address, count writes set the used
//   entry count of chunk address (saturated to the chunk size)
//  rsp channel (valid/ready): one response per search with found flag, first
//   equal position, lower-bound insert position and the chunk number
//  writes can follow back to back while no search runs
//  a search reads its first probe in the load state, then runs k halving
//   steps and registers its response in the final state, where k is
//   the number of halving steps over the used entries (0 for an empty chunk,
//   at most 7 for a full chunk of 64), set by one key table read and one
//   64-bit compare per step
//  req.ready is low while a search runs; a finished response waits in the
//   output register, and a following search holds in its final state until
//   the receiver takes it
//  reset clears the chunk counts and the sequencer, not the key table; the
//   user, unchecked by the block, must read an entry only after it was written
// ----------------------------------------------------------------------------
module chunked_sorted_key_search (
	input  logic        clk,
	input  logic        arst_n,
	csks_req_if.sink    req,
	csks_rsp_if.source  rsp
);

	csks_pkg::ram_wr_t          ram_wr;
	csks_pkg::ram_rd_t          ram_rd;
	logic [csks_pkg::KEY_W-1:0] ram_data;

	csks_search_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.ram_wr   (ram_wr),
		.ram_rd   (ram_rd),
		.ram_data (ram_data)
	);

	csks_key_ram u_ram (
		.clk     (clk),
		.wr      (ram_wr),
		.rd      (ram_rd),
		.rd_data (ram_data)
	);

endmodule

FILE: rtl/csks_key_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csks_key_ram
// key table, one write port and one registered read port
// ----------------------------------------------------------------------------
module csks_key_ram (
	input  logic                        clk,
	input  csks_pkg::ram_wr_t           wr,
	input  csks_pkg::ram_rd_t           rd,
	output logic [csks_pkg::KEY_W-1:0]  rd_data
);

	logic [csks_pkg::KEY_W-1:0] mem [csks_pkg::TABLE_DEPTH];
	logic [csks_pkg::KEY_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data_q <= mem[rd.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/csks_search_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csks_search_seq
// request decode, chunk counts and the lower-bound halving sequencer
// ----------------------------------------------------------------------------
module csks_search_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	csks_req_if.sink                    req,
	csks_rsp_if.source                  rsp,
	output csks_pkg::ram_wr_t           ram_wr,
	output csks_pkg::ram_rd_t           ram_rd,
	input  logic [csks_pkg::KEY_W-1:0]  ram_data
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_LOAD  = 4'b0010,
		ST_SRCH  = 4'b0100,
		ST_FINAL = 4'b1000
	} state_t;

	state_t                            state_q;
	logic [csks_pkg::CNT_W-1:0]        cnt_q [csks_pkg::NUM_CHUNKS];
	logic [csks_pkg::KEY_W-1:0]        key_q;
	logic [csks_pkg::CHUNK_SEL_W-1:0]  chunk_q;
	logic [csks_pkg::POS_W-1:0]        lo_q;
	logic [csks_pkg::POS_W-1:0]        hi_q;
	logic [csks_pkg::POS_W-1:0]        mid_q;
	logic [csks_pkg::POS_W-1:0]        end_q;
	logic                              out_valid_q;
	logic                              found_q;
	logic [csks_pkg::ADDR_W-1:0]       match_q;
	logic [csks_pkg::POS_W-1:0]        insert_q;
	logic [csks_pkg::CHUNK_SEL_W-1:0]  chunk_out_q;

	logic                              accept;
	logic [csks_pkg::CNT_W-1:0]        cnt_sat;
	logic [csks_pkg::POS_W-1:0]        start_w;
	logic [csks_pkg::POS_W-1:0]        load_hi;
	logic [csks_pkg::POS_W-1:0]        load_mid;
	logic                              less;
	logic [csks_pkg::POS_W-1:0]        lo_n;
	logic [csks_pkg::POS_W-1:0]        hi_n;
	logic [csks_pkg::POS_W-1:0]        mid_n;
	logic                              hit;
	logic                              out_free;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || rsp.ready;

	assign cnt_sat = (req.count > csks_pkg::CNT_W'(csks_pkg::CHUNK_SIZE)) ?
		csks_pkg::CNT_W'(csks_pkg::CHUNK_SIZE) : req.count;

	// chunk window and first probe
	assign start_w  = {1'b0, chunk_q, {csks_pkg::CHUNK_LOG{1'b0}}};
	assign load_hi  = start_w + csks_pkg::POS_W'(cnt_q[chunk_q]);
	assign load_mid = start_w + ((load_hi - start_w) >> 1);

	// shared compare and halving step
	assign less  = ram_data < key_q;
	assign lo_n  = less ? mid_q + csks_pkg::POS_W'(1) : lo_q;
	assign hi_n  = less ? hi_q : mid_q;
	assign mid_n = lo_n + ((hi_n - lo_n) >> 1);

	assign hit = (lo_q < end_q) && (ram_data == key_q);

	assign ram_wr.en   = accept && (req.action == csks_pkg::ACT_WRITE_KEY);
	assign ram_wr.addr = req.address;
	assign ram_wr.data = req.key;

	always_comb begin
		ram_rd.en   = 1'b0;
		ram_rd.addr = '0;
		unique case (state_q)
			ST_LOAD: begin
				ram_rd.en   = 1'b1;
				ram_rd.addr = (start_w < load_hi) ? load_mid[csks_pkg::ADDR_W-1:0] :
					start_w[csks_pkg::ADDR_W-1:0];
			end
			ST_SRCH: begin
				ram_rd.en   = 1'b1;
				ram_rd.addr = (lo_n < hi_n) ? mid_n[csks_pkg::ADDR_W-1:0] :
					lo_n[csks_pkg::ADDR_W-1:0];
			end
			ST_IDLE, ST_FINAL: begin
				ram_rd.en   = 1'b0;
			end
			default: begin
				ram_rd.en   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < csks_pkg::NUM_CHUNKS; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			if (state_q == ST_FINAL && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && req.action == csks_pkg::ACT_WRITE_COUNT) begin
						cnt_q[req.address[csks_pkg::CHUNK_SEL_W-1:0]] <= cnt_sat;
					end
					if (accept && req.action == csks_pkg::ACT_SEARCH) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= (start_w < load_hi) ? ST_SRCH : ST_FINAL;
				end
				ST_SRCH: begin
					if (!(lo_n < hi_n)) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q   <= req.key;
			chunk_q <= req.key[csks_pkg::KEY_W-1 -: csks_pkg::CHUNK_SEL_W];
		end
		if (state_q == ST_LOAD) begin
			lo_q  <= start_w;
			hi_q  <= load_hi;
			end_q <= load_hi;
			mid_q <= load_mid;
		end
		if (state_q == ST_SRCH) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			mid_q <= mid_n;
		end
		if (state_q == ST_FINAL && out_free) begin
			found_q     <= hit;
			match_q     <= hit ? lo_q[csks_pkg::ADDR_W-1:0] : '0;
			insert_q    <= lo_q;
			chunk_out_q <= chunk_q;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.found           = found_q;
	assign rsp.match_position  = match_q;
	assign rsp.insert_position = insert_q;
	assign rsp.chunk_number    = chunk_out_q;

`ifndef ASSERT_OFF
	a_window_open: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SRCH |-> lo_q < hi_q)
		else $error("search window empty while halving");

	a_window_in_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SRCH |-> lo_q >= start_w && hi_q <= end_q && mid_q < hi_q)
		else $error("search window left its chunk");

	a_match_is_insert: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.found |-> rsp.match_position ==
			rsp.insert_position[csks_pkg::ADDR_W-1:0])
		else $error("match position differs from lower bound");

	a_insert_in_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.insert_position[csks_pkg::POS_W-1:csks_pkg::CHUNK_LOG] ==
			{1'b0, rsp.chunk_number} ||
			rsp.insert_position == {1'b0, rsp.chunk_number, {csks_pkg::CHUNK_LOG{1'b0}}} +
			csks_pkg::POS_W'(csks_pkg::CHUNK_SIZE))
		else $error("insert position outside its chunk");

	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.action == csks_pkg::ACT_SEARCH |=> !req.ready)
		else $error("request taken while a search runs");
`endif

endmodule
